@@ rtl/twsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twsp_pkg
// Shared types, constants and helpers for the time-window shortest path unit.
// ----------------------------------------------------------------------------
package twsp_pkg;

  // Time word width and the all-ones value that stands for infinity.
  localparam int TIME_BITS = 48;
  localparam logic [TIME_BITS-1:0] TIME_INF = {TIME_BITS{1'b1}};

  // Node addressing is fixed by the eight-bit node fields.
  localparam int NODE_BITS  = 8;
  localparam int NODE_LIMIT = 256;
  localparam int COUNT_BITS = 9;
  localparam int COST_BITS  = 32;

  // Default depth of the edge table.
  localparam int EDGE_LIMIT_DEFAULT = 1024;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_NODE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_START = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_END   = 2'd2;

  // Request opcodes.
  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_SOLVE    = 1'b1;

  // One edge table entry.
  typedef struct packed {
    logic                 windowed;
    logic [COST_BITS-1:0] weight;
    logic [NODE_BITS-1:0] dst;
    logic [NODE_BITS-1:0] src;
  } edge_entry_t;

  // One heap entry; ordering is by key, then by vertex.
  typedef struct packed {
    logic [TIME_BITS-1:0] key;
    logic [NODE_BITS-1:0] vertex;
  } heap_entry_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_POP_TOP,
    ST_POP_LAST,
    ST_POP_PLACE,
    ST_SD_LEFT,
    ST_SD_RIGHT,
    ST_SD_PICK,
    ST_CHK_READ,
    ST_CHK,
    ST_EDGE_READ,
    ST_EDGE_ARR,
    ST_EDGE_CMP,
    ST_SU_READ,
    ST_SU_CMP,
    ST_FIN_READ,
    ST_FIN,
    ST_OUT
  } state_t;

  // Strict heap order: the concatenation compares key first, then vertex.
  function automatic logic heap_less(input heap_entry_t a, input heap_entry_t b);
    heap_less = ({a.key, a.vertex} < {b.key, b.vertex});
  endfunction

endpackage

@@ rtl/time_window_shortest_path_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_window_shortest_path_unit
// Edge loader and Dijkstra solver with a memory-based binary min-heap.
// ----------------------------------------------------------------------------
// An add-edge request is taken in idle; the unit is ready again next cycle.
// A solve request pops the heap, sifts down, scans the edge table for edges
// that leave the popped vertex and sifts each improved node up, all through
// the heap memory, then reads the target time in a finish step; the result
// then waits in an output register.
// Reset (synchronous) empties the edge table and heap and restores the
// configuration registers; node times are invalidated at the start of a solve.
module time_window_shortest_path_unit #(
  parameter int EDGE_LIMIT = twsp_pkg::EDGE_LIMIT_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // Request stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [47:0]                        s_tdata,  // from_node, to_node, edge_cost
  input  logic [1:0]                         s_tuser,  // opcode, edge_kind
  // Result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [47:0]                        m_tdata,  // arrival_time
  output logic [0:0]                         m_tuser,  // reachable
  // Configuration writes
  input  logic                               cfg_we,
  input  logic [twsp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [47:0]                        cfg_data
);

  localparam int TW   = twsp_pkg::TIME_BITS;
  localparam int NB   = twsp_pkg::NODE_BITS;
  localparam int CB   = twsp_pkg::COUNT_BITS;
  localparam int HEAP_CAP = EDGE_LIMIT + 1;
  localparam int EAW  = (EDGE_LIMIT > 1) ? $clog2(EDGE_LIMIT) : 1;
  localparam int ECW  = $clog2(EDGE_LIMIT + 1);
  localparam int HAW  = $clog2(HEAP_CAP);
  localparam int HCW  = $clog2(HEAP_CAP + 1);

  typedef twsp_pkg::edge_entry_t edge_entry_t;
  typedef twsp_pkg::heap_entry_t heap_entry_t;

  // Control and datapath registers
  twsp_pkg::state_t state, state_next;
  logic [CB-1:0]  node_count;
  logic [TW-1:0]  window_start;
  logic [TW-1:0]  window_end;
  logic [ECW-1:0] edge_total, edge_total_next;
  logic [ECW-1:0] e_idx, e_idx_next;
  logic [HCW-1:0] heap_fill, heap_fill_next;
  logic [HCW-1:0] hole, hole_next;
  heap_entry_t    item, item_next;
  heap_entry_t    cur, cur_next;
  heap_entry_t    lval, lval_next;
  logic [CB-1:0]  n_nodes, n_nodes_next;
  logic [TW-1:0]  t_cur, t_cur_next;
  logic [TW-1:0]  t_win, t_win_next;
  logic [TW-1:0]  arr, arr_next;
  logic           m_valid, m_valid_next;
  logic           m_reach, m_reach_next;
  logic [TW-1:0]  m_time, m_time_next;
  logic [twsp_pkg::NODE_LIMIT-1:0] bt_valid;

  // Memory ports
  edge_entry_t    edge_mem [EDGE_LIMIT];
  logic           edge_we, edge_re;
  logic [EAW-1:0] edge_waddr, edge_raddr;
  edge_entry_t    edge_wdata, edge_rdata;

  heap_entry_t    heap_mem [HEAP_CAP];
  logic           heap_we, heap_re;
  logic [HAW-1:0] heap_waddr, heap_raddr;
  heap_entry_t    heap_wdata, heap_rdata;

  logic [TW-1:0]  bt_mem [twsp_pkg::NODE_LIMIT];
  logic           bt_we, bt_re, bt_clr;
  logic [NB-1:0]  bt_waddr, bt_raddr, bt_rsel;
  logic [TW-1:0]  bt_wdata, bt_rdata;

  // Combinational helpers
  logic           s_fire;
  logic [HCW:0]   left_idx, right_idx;
  logic [HCW-1:0] parent_idx;
  logic           left_ok, right_ok;
  logic [TW-1:0]  bt_val;
  logic [TW:0]    arr_sum;
  logic [TW-1:0]  dep;
  heap_entry_t    pick;
  logic [HCW-1:0] pick_idx;
  logic           moved;
  logic           usable;
  logic [CB-1:0]  n_clamped;

  assign s_fire     = s_tvalid && s_tready;
  assign left_idx   = {hole, 1'b1};
  assign right_idx  = left_idx + (HCW+1)'(1);
  assign left_ok    = left_idx < {1'b0, heap_fill};
  assign right_ok   = right_idx < {1'b0, heap_fill};
  assign parent_idx = (hole - HCW'(1)) >> 1;
  assign bt_val     = bt_valid[bt_rsel] ? bt_rdata : twsp_pkg::TIME_INF;
  assign dep        = edge_rdata.windowed ? t_win : t_cur;
  assign arr_sum    = {1'b0, dep} + (TW+1)'(edge_rdata.weight);

  // Node count clamped into the supported range.
  always_comb begin
    if (node_count == '0) begin
      n_clamped = CB'(1);
    end else if (node_count > CB'(twsp_pkg::NODE_LIMIT)) begin
      n_clamped = CB'(twsp_pkg::NODE_LIMIT);
    end else begin
      n_clamped = node_count;
    end
  end

  // Sift-down choice among the moving item and its two children.
  always_comb begin
    pick     = item;
    pick_idx = hole;
    moved    = 1'b0;
    if (twsp_pkg::heap_less(lval, pick)) begin
      pick     = lval;
      pick_idx = left_idx[HCW-1:0];
      moved    = 1'b1;
    end
    if (right_ok && twsp_pkg::heap_less(heap_rdata, pick)) begin
      pick     = heap_rdata;
      pick_idx = right_idx[HCW-1:0];
      moved    = 1'b1;
    end
  end

  // A relaxation is usable if it improves the best time, unless a windowed edge lands after the window end.
  assign usable = !(edge_rdata.windowed && (arr > window_end)) && (bt_val > arr);

  // Sequencer: next state, memory strobes and next register values
  always_comb begin
    state_next      = state;
    edge_total_next = edge_total;
    e_idx_next      = e_idx;
    heap_fill_next  = heap_fill;
    hole_next       = hole;
    item_next       = item;
    cur_next        = cur;
    lval_next       = lval;
    n_nodes_next    = n_nodes;
    t_cur_next      = t_cur;
    t_win_next      = t_win;
    arr_next        = arr;
    m_valid_next    = m_valid;
    m_reach_next    = m_reach;
    m_time_next     = m_time;
    s_tready        = 1'b0;
    edge_we         = 1'b0;
    edge_waddr      = edge_total[EAW-1:0];
    edge_wdata      = '{windowed: s_tuser[1], weight: s_tdata[47:16],
                        dst: s_tdata[15:8], src: s_tdata[7:0]};
    edge_re         = 1'b0;
    edge_raddr      = e_idx[EAW-1:0];
    heap_we         = 1'b0;
    heap_waddr      = hole[HAW-1:0];
    heap_wdata      = item;
    heap_re         = 1'b0;
    heap_raddr      = '0;
    bt_we           = 1'b0;
    bt_clr          = 1'b0;
    bt_waddr        = edge_rdata.dst;
    bt_wdata        = arr;
    bt_re           = 1'b0;
    bt_raddr        = cur.vertex;

    unique case (state)
      twsp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_fire) begin
          if (s_tuser[0] == twsp_pkg::OP_ADD_EDGE) begin
            if (edge_total < ECW'(EDGE_LIMIT)) begin
              edge_we         = 1'b1;
              edge_total_next = edge_total + ECW'(1);
            end
          end else begin
            // Start a solve: node 0 at time zero, heap holds only node 0.
            n_nodes_next   = n_clamped;
            bt_clr         = 1'b1;
            bt_we          = 1'b1;
            bt_waddr       = '0;
            bt_wdata       = '0;
            heap_we        = 1'b1;
            heap_waddr     = '0;
            heap_wdata     = '0;
            heap_fill_next = HCW'(1);
            state_next     = twsp_pkg::ST_POP_TOP;
          end
        end
      end

      // Pop: read the top, then the last entry that refills the root.
      twsp_pkg::ST_POP_TOP: begin
        if (heap_fill == '0) begin
          state_next = twsp_pkg::ST_FIN_READ;
        end else begin
          heap_re        = 1'b1;
          heap_raddr     = '0;
          heap_fill_next = heap_fill - HCW'(1);
          state_next     = twsp_pkg::ST_POP_LAST;
        end
      end

      twsp_pkg::ST_POP_LAST: begin
        cur_next   = heap_rdata;
        heap_re    = 1'b1;
        heap_raddr = heap_fill[HAW-1:0];
        state_next = twsp_pkg::ST_POP_PLACE;
      end

      twsp_pkg::ST_POP_PLACE: begin
        item_next  = heap_rdata;
        hole_next  = '0;
        state_next = (heap_fill == '0) ? twsp_pkg::ST_CHK_READ : twsp_pkg::ST_SD_LEFT;
      end

      // Sift-down: move the hole towards the smaller child.
      twsp_pkg::ST_SD_LEFT: begin
        if (left_ok) begin
          heap_re    = 1'b1;
          heap_raddr = left_idx[HAW-1:0];
          state_next = twsp_pkg::ST_SD_RIGHT;
        end else begin
          heap_we    = 1'b1;
          state_next = twsp_pkg::ST_CHK_READ;
        end
      end

      twsp_pkg::ST_SD_RIGHT: begin
        lval_next = heap_rdata;
        if (right_ok) begin
          heap_re    = 1'b1;
          heap_raddr = right_idx[HAW-1:0];
        end
        state_next = twsp_pkg::ST_SD_PICK;
      end

      twsp_pkg::ST_SD_PICK: begin
        heap_we = 1'b1;
        if (moved) begin
          heap_wdata = pick;
          hole_next  = pick_idx;
          state_next = twsp_pkg::ST_SD_LEFT;
        end else begin
          state_next = twsp_pkg::ST_CHK_READ;
        end
      end

      // Skip stale entries and vertices outside the graph.
      twsp_pkg::ST_CHK_READ: begin
        bt_re      = 1'b1;
        bt_raddr   = cur.vertex;
        state_next = twsp_pkg::ST_CHK;
      end

      twsp_pkg::ST_CHK: begin
        if (({1'b0, cur.vertex} >= n_nodes) || (cur.key > bt_val)) begin
          state_next = twsp_pkg::ST_POP_TOP;
        end else begin
          t_cur_next = bt_val;
          t_win_next = (bt_val > window_start) ? bt_val : window_start;
          e_idx_next = '0;
          state_next = twsp_pkg::ST_EDGE_READ;
        end
      end

      // Edge scan: one table entry per pass.
      twsp_pkg::ST_EDGE_READ: begin
        if (e_idx == edge_total) begin
          state_next = twsp_pkg::ST_POP_TOP;
        end else begin
          edge_re    = 1'b1;
          state_next = twsp_pkg::ST_EDGE_ARR;
        end
      end

      twsp_pkg::ST_EDGE_ARR: begin
        if ((edge_rdata.src != cur.vertex) || ({1'b0, edge_rdata.dst} >= n_nodes)) begin
          e_idx_next = e_idx + ECW'(1);
          state_next = twsp_pkg::ST_EDGE_READ;
        end else begin
          arr_next   = arr_sum[TW] ? twsp_pkg::TIME_INF : arr_sum[TW-1:0];
          bt_re      = 1'b1;
          bt_raddr   = edge_rdata.dst;
          state_next = twsp_pkg::ST_EDGE_CMP;
        end
      end

      twsp_pkg::ST_EDGE_CMP: begin
        e_idx_next = e_idx + ECW'(1);
        state_next = twsp_pkg::ST_EDGE_READ;
        if (usable) begin
          bt_we = 1'b1;
          if (heap_fill < HCW'(HEAP_CAP)) begin
            item_next      = '{key: arr, vertex: edge_rdata.dst};
            hole_next      = heap_fill;
            heap_fill_next = heap_fill + HCW'(1);
            e_idx_next     = e_idx;
            state_next     = twsp_pkg::ST_SU_READ;
          end
        end
      end

      // Sift-up: move the hole towards the root while the item is smaller.
      twsp_pkg::ST_SU_READ: begin
        if (hole == '0) begin
          heap_we    = 1'b1;
          e_idx_next = e_idx + ECW'(1);
          state_next = twsp_pkg::ST_EDGE_READ;
        end else begin
          heap_re    = 1'b1;
          heap_raddr = parent_idx[HAW-1:0];
          state_next = twsp_pkg::ST_SU_CMP;
        end
      end

      twsp_pkg::ST_SU_CMP: begin
        heap_we = 1'b1;
        if (twsp_pkg::heap_less(item, heap_rdata)) begin
          heap_wdata = heap_rdata;
          hole_next  = parent_idx;
          state_next = twsp_pkg::ST_SU_READ;
        end else begin
          e_idx_next = e_idx + ECW'(1);
          state_next = twsp_pkg::ST_EDGE_READ;
        end
      end

      // Finish: read the target time, load the result register and empty the edge table.
      twsp_pkg::ST_FIN_READ: begin
        bt_re      = 1'b1;
        bt_raddr   = NB'(n_nodes - CB'(1));
        state_next = twsp_pkg::ST_FIN;
      end

      twsp_pkg::ST_FIN: begin
        m_valid_next    = 1'b1;
        m_reach_next    = (bt_val != twsp_pkg::TIME_INF);
        m_time_next     = (bt_val != twsp_pkg::TIME_INF) ? bt_val : '0;
        edge_total_next = '0;
        state_next      = twsp_pkg::ST_OUT;
      end

      twsp_pkg::ST_OUT: begin
        if (m_tready) begin
          m_valid_next = 1'b0;
          state_next   = twsp_pkg::ST_IDLE;
        end
      end

      default: state_next = twsp_pkg::ST_IDLE;
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= twsp_pkg::ST_IDLE;
      edge_total <= '0;
      heap_fill  <= '0;
      m_valid    <= 1'b0;
      bt_valid   <= '0;
    end else begin
      state      <= state_next;
      edge_total <= edge_total_next;
      heap_fill  <= heap_fill_next;
      m_valid    <= m_valid_next;
      if (bt_clr) begin
        bt_valid <= twsp_pkg::NODE_LIMIT'(1);
      end else if (bt_we) begin
        bt_valid[bt_waddr] <= 1'b1;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count   <= CB'(1);
      window_start <= '0;
      window_end   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        twsp_pkg::REG_NODE_COUNT:   node_count   <= cfg_data[CB-1:0];
        twsp_pkg::REG_WINDOW_START: window_start <= cfg_data[TW-1:0];
        twsp_pkg::REG_WINDOW_END:   window_end   <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    e_idx   <= e_idx_next;
    hole    <= hole_next;
    item    <= item_next;
    cur     <= cur_next;
    lval    <= lval_next;
    n_nodes <= n_nodes_next;
    t_cur   <= t_cur_next;
    t_win   <= t_win_next;
    arr     <= arr_next;
    m_reach <= m_reach_next;
    m_time  <= m_time_next;
  end

  // Edge table memory
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    if (edge_re) begin
      edge_rdata <= edge_mem[edge_raddr];
    end
  end

  // Heap memory
  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    if (heap_re) begin
      heap_rdata <= heap_mem[heap_raddr];
    end
  end

  // Best arrival time memory; the read address is kept for the valid lookup
  always_ff @(posedge clk) begin
    if (bt_we) begin
      bt_mem[bt_waddr] <= bt_wdata;
    end
    if (bt_re) begin
      bt_rdata <= bt_mem[bt_raddr];
      bt_rsel  <= bt_raddr;
    end
  end

  // Result port
  assign m_tvalid   = m_valid;
  assign m_tdata    = m_time;
  assign m_tuser[0] = m_reach;

  // Checks
  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    heap_fill <= HCW'(HEAP_CAP))
    else $error("heap fill above capacity");

  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    edge_total <= ECW'(EDGE_LIMIT))
    else $error("edge count above table depth");

  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("unreachable result carries a nonzero time");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("request taken while a result is pending");

  a_solve_clears: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid)) |-> (edge_total == '0))
    else $error("edge table not cleared after a solve");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the time-window shortest path unit. Edge loads and
// solve requests are driven over the request stream with random gaps; a local
// Dijkstra predictor computes the arrival time for every solve, and each
// result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int EDGES = 1024;
  localparam logic [47:0] INF = {48{1'b1}};

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we;
  logic [twsp_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [47:0] cfg_data;

  time_window_shortest_path_unit i_dut (.*);

  // Predictor state: configuration and the loaded edge list.
  logic [8:0]  node_cfg;
  logic [47:0] win_open;
  logic [47:0] win_close;
  logic [7:0]  edge_from [EDGES];
  logic [7:0]  edge_to   [EDGES];
  logic [31:0] edge_len  [EDGES];
  logic        edge_win  [EDGES];
  int          edge_cnt;

  // Expected results, reachable flag in bit 48.
  logic [48:0] route_queue[$];
  int          fail_count;
  int          solve_count;
  int          reach_count;
  int          hold_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [47:0] sat_sum(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return (s > {1'b0, INF}) ? INF : s[47:0];
  endfunction

  // Earliest arrival at the last node; visiting order does not change the
  // fixed point, so a plain array-based Dijkstra is enough.
  function automatic logic [48:0] shortest_route();
    logic [47:0] best [256];
    bit          done [256];
    logic [47:0] t, arr, dep;
    int n, cur, e;
    n = node_cfg == 0 ? 1 : (node_cfg > 256 ? 256 : node_cfg);
    for (int v = 0; v < 256; v++) begin
      best[v] = INF;
      done[v] = 0;
    end
    best[0] = 0;
    forever begin
      cur = -1;
      for (int v = 0; v < n; v++)
        if (!done[v] && best[v] != INF && (cur < 0 || best[v] < best[cur])) cur = v;
      if (cur < 0) break;
      done[cur] = 1;
      t = best[cur];
      for (e = 0; e < edge_cnt; e++) begin
        if (edge_from[e] != cur || edge_to[e] >= n) continue;
        if (edge_win[e]) begin
          dep = t > win_open ? t : win_open;
          arr = sat_sum(dep, edge_len[e]);
          if (arr > win_close) continue;
        end else begin
          arr = sat_sum(t, edge_len[e]);
        end
        if (best[edge_to[e]] > arr) best[edge_to[e]] = arr;
      end
    end
    t = best[n-1];
    return (t == INF) ? 49'd0 : {1'b1, t};
  endfunction

  // One register write, after which the write port is left idle before the task returns.
  task automatic write_reg(input logic [twsp_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == twsp_pkg::REG_NODE_COUNT) node_cfg = val[8:0];
    else if (idx == twsp_pkg::REG_WINDOW_START) win_open = val;
    else win_close = val;
    @(posedge clk);
  endtask

  // Sends one request and updates the predictor once it is accepted.
  task automatic send_request(input logic op, input logic [7:0] src, input logic [7:0] dst,
                              input logic [31:0] cost, input logic kind);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {cost, dst, src};
    s_tuser  <= {kind, op};
    do @(posedge clk); while (!s_tready);
    if (op == twsp_pkg::OP_SOLVE) begin
      route_queue.insert(route_queue.size(), shortest_route());
      edge_cnt = 0;
    end else if (edge_cnt < EDGES) begin
      edge_from[edge_cnt] = src;
      edge_to[edge_cnt]   = dst;
      edge_len[edge_cnt]  = cost;
      edge_win[edge_cnt]  = kind;
      edge_cnt++;
    end
  endtask

  task automatic add_edge(input logic [7:0] s, input logic [7:0] d, input logic [31:0] c,
                          input logic k);
    send_request(twsp_pkg::OP_ADD_EDGE, s, d, c, k);
  endtask

  task automatic solve_now();
    send_request(twsp_pkg::OP_SOLVE, 8'($urandom), 8'($urandom), $urandom,
                 1'($urandom));
  endtask

  // Drops the request valid and waits until every result has been taken.
  task automatic wait_idle();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (route_queue.size() != 0 && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  // Receiver: a random wait after each result, plus one long hold-off.
  initial begin
    int wait_left;
    wait_left = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) wait_left = $urandom_range(0, 6);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else if (wait_left > 0) begin
        m_tready <= 1'b0;
        wait_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Result checker.
  initial begin
    logic [48:0] want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (route_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: expected none got %0b/%0d", m_tuser[0], m_tdata);
        end else begin
          want = route_queue.pop_front();
          solve_count++;
          if (m_tuser[0]) reach_count++;
          if (m_tuser[0] !== want[48] || m_tdata !== want[47:0]) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %0b/%0d got %0b/%0d",
                       want[48], want[47:0], m_tuser[0], m_tdata);
          end
        end
      end
    end
  end

  task automatic test_directed();
    // Single node: reachable at time zero.
    solve_now();
    wait_idle();
    write_reg(twsp_pkg::REG_NODE_COUNT, 48'd4);
    write_reg(twsp_pkg::REG_WINDOW_START, 48'd100);
    write_reg(twsp_pkg::REG_WINDOW_END, 48'd150);
    add_edge(0, 1, 10, 0);
    add_edge(1, 3, 30, 1);
    add_edge(0, 3, 500, 0);
    add_edge(1, 2, 60, 1);
    add_edge(2, 3, 0, 0);
    add_edge(3, 9, 1, 0);
    add_edge(9, 3, 0, 0);
    solve_now();
    // No edges: target unreachable.
    solve_now();
    // Maximum edge costs along a path; the sum stays below infinity.
    add_edge(0, 1, 32'hFFFF_FFFF, 0);
    add_edge(1, 2, 32'hFFFF_FFFF, 0);
    add_edge(2, 3, 32'hFFFF_FFFF, 0);
    solve_now();
    wait_idle();
    write_reg(twsp_pkg::REG_NODE_COUNT, 48'd0);
    solve_now();
    wait_idle();
    write_reg(twsp_pkg::REG_NODE_COUNT, 48'h1FF);
    write_reg(twsp_pkg::REG_WINDOW_START, INF);
    write_reg(twsp_pkg::REG_WINDOW_END, INF);
    add_edge(0, 255, 5, 1);
    add_edge(0, 255, 7, 0);
    solve_now();
    wait_idle();
  endtask

  task automatic test_random_graphs(input int rounds, input int max_nodes);
    int n, ne;
    for (int r = 0; r < rounds; r++) begin
      wait_idle();
      n = $urandom_range(1, max_nodes);
      write_reg(twsp_pkg::REG_NODE_COUNT,
                $urandom_range(0, 3) == 0 ? 48'(9'($urandom)) : 48'(n));
      write_reg(twsp_pkg::REG_WINDOW_START,
                $urandom_range(0, 4) == 0 ? 48'({$urandom, $urandom})
                                          : 48'($urandom_range(0, 300)));
      write_reg(twsp_pkg::REG_WINDOW_END,
                $urandom_range(0, 4) == 0 ? 48'({$urandom, $urandom})
                                          : 48'($urandom_range(0, 900)));
      for (int s = 0; s < 4; s++) begin
        ne = $urandom_range(0, 14);
        for (int k = 0; k < ne; k++)
          add_edge($urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, n)),
                   $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, n)),
                   $urandom_range(0, 7) == 0 ? $urandom : 32'($urandom_range(0, 200)),
                   1'($urandom));
        solve_now();
      end
    end
  endtask

  // Fill the edge table past its limit so the surplus adds are dropped.
  task automatic test_full_table();
    wait_idle();
    write_reg(twsp_pkg::REG_NODE_COUNT, 48'd3);
    for (int k = 0; k < EDGES + 4; k++)
      add_edge(8'($urandom_range(0, 2)), 8'($urandom_range(0, 2)),
               32'($urandom_range(0, 99)), 1'($urandom));
    solve_now();
  endtask

  // Long receiver hold-off while solves keep coming.
  task automatic test_backpressure();
    wait_idle();
    write_reg(twsp_pkg::REG_NODE_COUNT, 48'd2);
    hold_cycles = 400;
    for (int k = 0; k < 8; k++) begin
      add_edge(0, 1, 32'($urandom_range(0, 50)), 0);
      solve_now();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_cycles = 0;
    fail_count = 0;
    solve_count = 0;
    reach_count = 0;
    node_cfg = 9'd1;
    win_open = '0;
    win_close = '0;
    edge_cnt = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_graphs(3, 12);
    test_backpressure();
    test_full_table();
    test_random_graphs(1, 255);
    wait_idle();
    $display("Covered %0d solves (%0d reachable) over random and windowed graphs,",
             solve_count, reach_count);
    $display("a full edge table and a long result stall; %0d mismatches.", fail_count);
    if (fail_count == 0 && route_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
